// ===== rtl/cpr_pkg.sv =====
// Shared types, constants and microcode table for the clock page replacement block.
`timescale 1ns / 1ps

package cpr_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed widths of the stream and register fields.
  localparam int PAGE_W     = 16;
  localparam int IDX_W      = 3;
  localparam int FAULT_W    = 16;
  localparam int AF_W       = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register map: index taken from paddr[2].
  localparam logic REG_ACTIVE_FRAMES = 1'b0;
  localparam logic [AF_W-1:0] ACTIVE_FRAMES_RST = 4'd8;

  // Branch conditions of the sequencer.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_HIT,
    COND_REF_SET,
    COND_OUT_BUSY
  } cond_e;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    STEP_FETCH,
    STEP_SEARCH,
    STEP_SWEEP,
    STEP_VICTIM,
    STEP_HIT,
    STEP_EMIT
  } step_e;

  // One control word: branch fields plus datapath operation strobes.
  typedef struct packed {
    cond_e cond;
    step_e jmp;
    step_e nxt;
    logic  in_ready;
    logic  search;
    logic  sweep;
    logic  victim;
    logic  hit_upd;
    logic  emit;
  } uword_t;

  // Datapath flags the sequencer branches on.
  typedef struct packed {
    logic in_valid;
    logic hit;
    logic ref_set;
    logic out_busy;
  } status_t;

  // Microcode ROM.
  function automatic uword_t ucode(step_e step);
    uword_t w;
    w = '0;
    unique case (step)
      STEP_FETCH: begin
        w.cond = COND_NO_INPUT; w.jmp = STEP_FETCH; w.nxt = STEP_SEARCH;
        w.in_ready = 1'b1;
      end
      STEP_SEARCH: begin
        w.cond = COND_HIT; w.jmp = STEP_HIT; w.nxt = STEP_SWEEP;
        w.search = 1'b1;
      end
      STEP_SWEEP: begin
        w.cond = COND_REF_SET; w.jmp = STEP_SWEEP; w.nxt = STEP_VICTIM;
        w.sweep = 1'b1;
      end
      STEP_VICTIM: begin
        w.cond = COND_ALWAYS; w.jmp = STEP_EMIT; w.nxt = STEP_EMIT;
        w.victim = 1'b1;
      end
      STEP_HIT: begin
        w.cond = COND_ALWAYS; w.jmp = STEP_EMIT; w.nxt = STEP_EMIT;
        w.hit_upd = 1'b1;
      end
      STEP_EMIT: begin
        w.cond = COND_OUT_BUSY; w.jmp = STEP_EMIT; w.nxt = STEP_FETCH;
        w.emit = 1'b1;
      end
      default: begin
        w.cond = COND_ALWAYS; w.jmp = STEP_FETCH; w.nxt = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/cpr_cfg_regs.sv =====
// APB register file holding the active frame count.
`timescale 1ns / 1ps

module cpr_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cpr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cpr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cpr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [cpr_pkg::AF_W-1:0]         active_frames_o
);

  logic [cpr_pkg::AF_W-1:0] active_q, active_d;
  logic                     sel_active;

  // Register index sits above the byte offset.
  assign sel_active = (paddr[2] == cpr_pkg::REG_ACTIVE_FRAMES);
  assign pready     = 1'b1;

  // Write on the access phase; other indexes are ignored.
  always_comb begin
    active_d = active_q;
    if (psel && penable && pwrite && pready && sel_active) begin
      active_d = pwdata[cpr_pkg::AF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= cpr_pkg::ACTIVE_FRAMES_RST;
    end else begin
      active_q <= active_d;
    end
  end

  // Read back the register, zero elsewhere.
  assign prdata = sel_active ? {{(cpr_pkg::APB_DATA_W-cpr_pkg::AF_W){1'b0}}, active_q}
                             : '0;
  assign active_frames_o = active_q;

endmodule

// ===== rtl/cpr_sequencer.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional branch.
`timescale 1ns / 1ps

module cpr_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpr_pkg::status_t status_i,
  output cpr_pkg::uword_t  uword_o
);

  cpr_pkg::step_e  pc_q, pc_d;
  cpr_pkg::uword_t uw;
  logic            taken;

  // Fetch the control word of the current step.
  assign uw      = cpr_pkg::ucode(pc_q);
  assign uword_o = uw;

  // Branch condition select.
  always_comb begin
    unique case (uw.cond)
      cpr_pkg::COND_ALWAYS:   taken = 1'b1;
      cpr_pkg::COND_NO_INPUT: taken = !status_i.in_valid;
      cpr_pkg::COND_HIT:      taken = status_i.hit;
      cpr_pkg::COND_REF_SET:  taken = status_i.ref_set;
      cpr_pkg::COND_OUT_BUSY: taken = status_i.out_busy;
      default:                taken = 1'b0;
    endcase
    pc_d = taken ? uw.jmp : uw.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= cpr_pkg::STEP_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/cpr_datapath.sv =====
// Frame table, clock hand, fault counter and output register driven by the microcode.
`timescale 1ns / 1ps

module cpr_datapath #(
  parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cpr_pkg::uword_t                   uword_i,
  output cpr_pkg::status_t                  status_o,
  input  logic [cpr_pkg::AF_W-1:0]          active_frames_i,
  input  logic                              s_tvalid_i,
  input  logic [cpr_pkg::IN_DATA_W-1:0]     s_tdata_i,
  output logic                              s_tready_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [cpr_pkg::OUT_DATA_W-1:0]    m_tdata_o,
  output logic [cpr_pkg::OUT_USER_W-1:0]    m_tuser_o
);

  localparam int HW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int PAD_W = cpr_pkg::OUT_DATA_W - cpr_pkg::IDX_W - cpr_pkg::PAGE_W
                         - cpr_pkg::FAULT_W;

  // Frame table.
  logic [PAGE_BITS-1:0] page_arr_q [FRAMES];
  logic [FRAMES-1:0]    valid_q;
  logic [FRAMES-1:0]    ref_q;

  // Working registers.
  logic [PAGE_BITS-1:0]        page_q;
  logic [HW-1:0]               hand_q;
  logic [HW-1:0]               h_q;
  logic [HW-1:0]               hit_idx_q;
  logic [cpr_pkg::FAULT_W-1:0] fault_q;

  // Result staging and output register.
  logic                         res_hit_q;
  logic [HW-1:0]                res_idx_q;
  logic                         res_ev_q;
  logic [PAGE_BITS-1:0]         res_ev_page_q;
  logic                         m_valid_q;
  logic                         out_hit_q;
  logic                         out_ev_q;
  logic [cpr_pkg::IDX_W-1:0]    out_idx_q;
  logic [cpr_pkg::PAGE_W-1:0]   out_ev_page_q;
  logic [cpr_pkg::FAULT_W-1:0]  out_fault_q;

  logic [CW-1:0] n_eff;
  logic [CW-1:0] h_inc;
  logic [HW-1:0] h_next;
  logic [HW-1:0] hand_start;
  logic          hit;
  logic [HW-1:0] hit_idx;
  logic          in_xfer;
  logic          out_busy;

  // Effective frame count: zero counts as one, clamp at the table depth.
  always_comb begin
    if (active_frames_i == '0) begin
      n_eff = CW'(1);
    end else if (32'(active_frames_i) > 32'(FRAMES)) begin
      n_eff = CW'(FRAMES);
    end else begin
      n_eff = CW'(active_frames_i);
    end
  end

  // Hand advance with wrap at the active count; restart if out of range.
  assign h_inc      = CW'(h_q) + CW'(1);
  assign h_next     = (h_inc >= n_eff) ? '0 : HW'(h_inc);
  assign hand_start = (CW'(hand_q) >= n_eff) ? '0 : hand_q;

  // Parallel compare over the active frames, lowest index wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if ((i < int'(n_eff)) && valid_q[i] && (page_arr_q[i] == page_q)) begin
        hit     = 1'b1;
        hit_idx = HW'(i);
      end
    end
  end

  assign in_xfer  = uword_i.in_ready && s_tvalid_i;
  assign out_busy = m_valid_q && !m_tready_i;

  assign status_o.in_valid = s_tvalid_i;
  assign status_o.hit      = hit;
  assign status_o.ref_set  = ref_q[h_q];
  assign status_o.out_busy = out_busy;

  // Control state: valid and reference bits, hand, fault count, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      ref_q     <= '0;
      hand_q    <= '0;
      fault_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (uword_i.search && !hit && (fault_q != '1)) begin
        fault_q <= fault_q + 1'b1;
      end
      if (uword_i.sweep && ref_q[h_q]) begin
        ref_q[h_q] <= 1'b0;
      end
      if (uword_i.victim) begin
        valid_q[h_q] <= 1'b1;
        ref_q[h_q]   <= 1'b1;
        hand_q       <= h_next;
      end
      if (uword_i.hit_upd) begin
        ref_q[hit_idx_q] <= 1'b1;
      end
      if (uword_i.emit && !out_busy) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      page_q <= PAGE_BITS'(s_tdata_i);
    end
    if (uword_i.search) begin
      hit_idx_q <= hit_idx;
      h_q       <= hand_start;
    end
    if (uword_i.sweep && ref_q[h_q]) begin
      h_q <= h_next;
    end
    if (uword_i.victim) begin
      page_arr_q[h_q] <= page_q;
      res_hit_q       <= 1'b0;
      res_idx_q       <= h_q;
      res_ev_q        <= valid_q[h_q];
      res_ev_page_q   <= valid_q[h_q] ? page_arr_q[h_q] : '0;
    end
    if (uword_i.hit_upd) begin
      res_hit_q     <= 1'b1;
      res_idx_q     <= hit_idx_q;
      res_ev_q      <= 1'b0;
      res_ev_page_q <= '0;
    end
    if (uword_i.emit && !out_busy) begin
      out_hit_q     <= res_hit_q;
      out_ev_q      <= res_ev_q;
      out_idx_q     <= cpr_pkg::IDX_W'(res_idx_q);
      out_ev_page_q <= cpr_pkg::PAGE_W'(res_ev_page_q);
      out_fault_q   <= fault_q;
    end
  end

  assign s_tready_o = uword_i.in_ready;
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{PAD_W{1'b0}}, out_fault_q, out_ev_page_q, out_idx_q};
  assign m_tuser_o  = {out_ev_q, out_hit_q};

endmodule

// ===== rtl/clock_page_replacement.sv =====
// Top level of the clock (second chance) page replacement block.
//
// Page references arrive on the s_axis stream, one page number per transfer.
// Each reference gives exactly one result transfer on m_axis: the frame that
// now holds the page, a hit flag, the evicted page on a replacing fault and
// the running fault count, which saturates at its maximum.
// The APB port holds one register, active_frames, at byte address 0; write it
// only while no reference is in flight.
// A microcoded sequencer runs each reference: fetch, parallel search, then on
// a hit one update step, on a miss one sweep step per frame the hand examines
// up to and including the first with a clear reference bit, plus one victim
// step, and a final emit step. The sweep examines one frame per cycle and
// passes at most the active frame count of set reference bits.
// The result sits in an output register; the next reference is fetched while
// it waits, and only the following emit step stalls on a held m_axis_tready.
// Reset empties all frames, clears the hand and fault count and sets
// active_frames to 8; a reference may be sent in the first cycle after reset.
`timescale 1ns / 1ps

module clock_page_replacement #(
  parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Reference stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cpr_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] page_number
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] frame_index, [18:3] evicted_page, [34:19] fault_total, [39:35] zero
  output logic [cpr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [cpr_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // [0] hit, [1] evicted_valid
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cpr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cpr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cpr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic [cpr_pkg::AF_W-1:0] active_frames;
  cpr_pkg::uword_t          uword;
  cpr_pkg::status_t         status;

  // Configuration register.
  cpr_cfg_regs u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .active_frames_o (active_frames)
  );

  // Control program.
  cpr_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .uword_o  (uword)
  );

  // Frame table and result path.
  cpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .uword_i         (uword),
    .status_o        (status),
    .active_frames_i (active_frames),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tdata_i       (s_axis_tdata),
    .s_tready_o      (s_axis_tready),
    .m_tvalid_o      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_o       (m_axis_tdata),
    .m_tuser_o       (m_axis_tuser)
  );

endmodule

// ===== rtl/cpr_checker.sv =====
// Port-level checker for the clock page replacement block, with its bind.
`timescale 1ns / 1ps

module cpr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cpr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [cpr_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its data.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && (m_axis_tdata[18:3] == 16'd0))
    else $error("eviction reported on a hit");

  // A fault result always carries a nonzero fault count.
  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[34:19] != 16'd0))
    else $error("fault reported with zero fault count");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
